/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL files.
// The macros expect the including module to have i_clk in scope, and i_rst_n for IGR_ASSERT.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, sampled on the rising clock edge and disabled during reset
`define IGR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Concurrent check that is also evaluated while reset is asserted
`define IGR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

/* rtl/igr_pkg.sv */
// Shared types and constants for the interval graph reachability block.
// Used by igr_ctrl, igr_datapath and the top level; no dependencies.
package igr_pkg;

    // default table depth
    localparam int ENTRIES_DEF = 128;

    // field widths of the streams
    localparam int END_W    = 32;
    localparam int ENTRY_W  = 8;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 80;
    localparam int M_DATA_W = 16;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

    // request kinds carried in tuser
    localparam logic REQ_INSERT = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;      // request taken this cycle
        logic clr_en;      // clear one visited mark
        logic pop;         // read top of walk stack
        logic rd_x;        // read endpoints of popped entry
        logic latch_x;     // capture endpoints of popped entry
        logic scan_start;  // start a scan over all stored entries
        logic out_load;    // load result into output register
    } t_ctrl_cmd;

    // status from the datapath to the controller
    typedef struct packed {
        logic is_insert;   // incoming request is an insert
        logic q_absent;    // incoming query names a missing entry
        logic clr_last;    // last mark of the clearing sweep
        logic stack_empty; // walk stack holds nothing
        logic scan_busy;   // scan pipeline still running
        logic out_free;    // output register can take a result
    } t_dp_status;

endpackage

/* rtl/igr_ctrl.sv */
// Sequencer for the interval graph reachability block.
// Depends on igr_pkg and assert_macros.svh; drives the datapath by commands.
`include "assert_macros.svh"

module igr_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  igr_pkg::t_dp_status   i_st,
    output igr_pkg::t_ctrl_cmd    o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_CLEAR  = 7'b0000010,
        S_POP    = 7'b0000100,
        S_ADDRX  = 7'b0001000,
        S_LATCHX = 7'b0010000,
        S_SCAN   = 7'b0100000,
        S_RESULT = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // next state and commands
    always_comb begin
        n_state          = r_state;
        o_cmd            = '0;
        o_cmd.accept     = w_accept;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (i_st.is_insert || i_st.q_absent) begin
                        n_state = S_RESULT;
                    end else begin
                        n_state = S_CLEAR;
                    end
                end
            end
            S_CLEAR: begin
                o_cmd.clr_en = 1'b1;
                if (i_st.clr_last) begin
                    n_state = S_POP;
                end
            end
            S_POP: begin
                if (i_st.stack_empty) begin
                    n_state = S_RESULT;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_ADDRX;
                end
            end
            S_ADDRX: begin
                o_cmd.rd_x = 1'b1;
                n_state    = S_LATCHX;
            end
            S_LATCHX: begin
                o_cmd.latch_x    = 1'b1;
                o_cmd.scan_start = 1'b1;
                n_state          = S_SCAN;
            end
            S_SCAN: begin
                if (!i_st.scan_busy) begin
                    n_state = S_POP;
                end
            end
            S_RESULT: begin
                if (i_st.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // a new request never lands on a running scan
    `IGR_ASSERT(a_ready_no_scan, o_s_tready |-> !i_st.scan_busy, "request taken while scan runs")
    // an insert goes straight to its result
    `IGR_ASSERT(a_insert_result, (w_accept && i_st.is_insert) |=> (r_state == S_RESULT), "insert did not reach result")

endmodule

/* rtl/igr_datapath.sv */
// Interval tables, visited marks, walk stack, scan pipeline and output register.
// Depends on igr_pkg and assert_macros.svh; controlled by igr_ctrl.
`include "assert_macros.svh"

module igr_datapath #(
    parameter int ENTRIES = igr_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  igr_pkg::t_ctrl_cmd            i_cmd,
    output igr_pkg::t_dp_status           o_st,
    input  logic [igr_pkg::S_DATA_W-1:0]  i_s_tdata,
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [igr_pkg::M_DATA_W-1:0]  o_m_tdata,
    output logic [igr_pkg::STATUS_W-1:0]  o_m_tuser
);

    localparam int IW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CMPW = (CW > igr_pkg::ENTRY_W) ? CW : igr_pkg::ENTRY_W;
    localparam int AW   = (CW + 1 > igr_pkg::ENTRY_W) ? CW + 1 : igr_pkg::ENTRY_W;
    localparam int EW   = igr_pkg::END_W;
    localparam int NW   = igr_pkg::ENTRY_W;

    // storage
    logic signed [EW-1:0] r_left_mem  [ENTRIES];
    logic signed [EW-1:0] r_right_mem [ENTRIES];
    logic                 r_vis       [ENTRIES];
    logic [IW-1:0]        r_stack     [ENTRIES];

    // control registers
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_depth;
    logic [IW-1:0]        r_clr_idx;
    logic [IW-1:0]        r_issue_idx;
    logic                 r_issuing;
    logic                 r_eval_vld;
    logic                 r_m_valid;

    // payload registers
    logic [IW-1:0]        r_start;
    logic [IW-1:0]        r_target;
    logic [IW-1:0]        r_eval_idx;
    logic [IW-1:0]        r_stack_q;
    logic signed [EW-1:0] r_l_q;
    logic signed [EW-1:0] r_r_q;
    logic                 r_vis_q;
    logic signed [EW-1:0] r_xl;
    logic signed [EW-1:0] r_xr;
    logic                 r_hit;
    logic [igr_pkg::STATUS_W-1:0] r_res_status;
    logic [NW-1:0]        r_res_assigned;
    logic                 r_out_reach;
    logic [igr_pkg::STATUS_W-1:0] r_out_status;
    logic [NW-1:0]        r_out_assigned;

    // request fields
    logic signed [EW-1:0] w_left;
    logic signed [EW-1:0] w_right;
    logic [NW-1:0]        w_a;
    logic [NW-1:0]        w_b;
    logic                 w_is_insert;
    logic                 w_full;
    logic                 w_absent;
    logic                 w_walk;
    logic [IW-1:0]        w_start;
    logic [IW-1:0]        w_tgt;
    logic [AW-1:0]        w_next_cnt;
    logic [IW-1:0]        w_last_idx;
    logic [IW-1:0]        w_rd_addr;
    logic                 w_take;
    logic                 w_vis_we;
    logic [IW-1:0]        w_vis_wa;
    logic                 w_vis_wd;

    assign w_left      = i_s_tdata[31:0];
    assign w_right     = i_s_tdata[63:32];
    assign w_a         = i_s_tdata[71:64];
    assign w_b         = i_s_tdata[79:72];
    assign w_is_insert = (i_s_tuser == igr_pkg::REQ_INSERT);
    assign w_full      = (r_count == CW'(ENTRIES));
    assign w_absent    = (w_a == '0) || (w_b == '0) ||
                         (CMPW'(w_a) > CMPW'(r_count)) || (CMPW'(w_b) > CMPW'(r_count));
    assign w_walk      = i_cmd.accept && !w_is_insert && !w_absent;
    assign w_start     = IW'(CMPW'(w_a) - CMPW'(1));
    assign w_tgt       = IW'(CMPW'(w_b) - CMPW'(1));
    assign w_next_cnt  = AW'(r_count) + AW'(1);
    assign w_last_idx  = IW'(r_count - CW'(1));

    // status to the controller
    assign o_st.is_insert   = w_is_insert;
    assign o_st.q_absent    = w_absent;
    assign o_st.clr_last    = (r_clr_idx == w_last_idx);
    assign o_st.stack_empty = (r_depth == '0);
    assign o_st.scan_busy   = r_issuing || r_eval_vld;
    assign o_st.out_free    = !r_m_valid || i_m_tready;

    // interval tables: insert write, one shared read port
    assign w_rd_addr = i_cmd.rd_x ? r_stack_q : r_issue_idx;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_is_insert && !w_full) begin
            r_left_mem[IW'(r_count)]  <= w_left;
            r_right_mem[IW'(r_count)] <= w_right;
        end
        r_l_q <= r_left_mem[w_rd_addr];
        r_r_q <= r_right_mem[w_rd_addr];
    end

    // entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.accept && w_is_insert && !w_full) begin
            r_count <= r_count + CW'(1);
        end
    end

    // step test: an endpoint of the popped entry strictly inside the scanned one
    assign w_take = r_eval_vld && !r_vis_q &&
                    (((r_xl > r_l_q) && (r_xl < r_r_q)) ||
                     ((r_xr > r_l_q) && (r_xr < r_r_q)));

    // visited marks: clearing sweep or mark on a step
    assign w_vis_we = i_cmd.clr_en || w_take;
    assign w_vis_wa = i_cmd.clr_en ? r_clr_idx : r_eval_idx;
    assign w_vis_wd = i_cmd.clr_en ? (r_clr_idx == r_start) : 1'b1;

    always_ff @(posedge i_clk) begin
        if (w_vis_we) begin
            r_vis[w_vis_wa] <= w_vis_wd;
        end
        r_vis_q <= r_vis[r_issue_idx];
    end

    // walk stack: seeded with the start entry, pushed on steps, popped by the controller
    always_ff @(posedge i_clk) begin
        if (w_walk) begin
            r_stack[0] <= w_start;
        end else if (w_take) begin
            r_stack[IW'(r_depth)] <= r_eval_idx;
        end
        if (i_cmd.pop) begin
            r_stack_q <= r_stack[IW'(r_depth - CW'(1))];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth <= '0;
        end else if (w_walk) begin
            r_depth <= CW'(1);
        end else if (w_take) begin
            r_depth <= r_depth + CW'(1);
        end else if (i_cmd.pop) begin
            r_depth <= r_depth - CW'(1);
        end
    end

    // clearing sweep index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.accept) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_idx <= r_clr_idx + IW'(1);
        end
    end

    // scan pipeline: issue an address, test it in the next cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue_idx <= '0;
            r_issuing   <= 1'b0;
            r_eval_vld  <= 1'b0;
        end else if (i_cmd.scan_start) begin
            r_issue_idx <= '0;
            r_issuing   <= 1'b1;
            r_eval_vld  <= 1'b0;
        end else begin
            r_eval_vld <= r_issuing;
            if (r_issuing) begin
                r_issue_idx <= r_issue_idx + IW'(1);
                if (r_issue_idx == w_last_idx) begin
                    r_issuing <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_issuing) begin
            r_eval_idx <= r_issue_idx;
        end
        if (i_cmd.latch_x) begin
            r_xl <= r_l_q;
            r_xr <= r_r_q;
        end
    end

    // request decode and reach flag
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (w_is_insert) begin
                r_res_status   <= w_full ? igr_pkg::ST_FULL : igr_pkg::ST_OK;
                r_res_assigned <= w_full ? '0 : w_next_cnt[NW-1:0];
                r_hit          <= 1'b0;
            end else begin
                r_res_status   <= w_absent ? igr_pkg::ST_ABSENT : igr_pkg::ST_OK;
                r_res_assigned <= '0;
                r_hit          <= !w_absent && (w_start == w_tgt);
                r_start        <= w_start;
                r_target       <= w_tgt;
            end
        end else if (w_take && (r_eval_idx == r_target)) begin
            r_hit <= 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_m_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_reach    <= r_hit;
            r_out_status   <= r_res_status;
            r_out_assigned <= r_res_assigned;
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {(igr_pkg::M_DATA_W - NW - 1)'(0), r_out_assigned, r_out_reach};
    assign o_m_tuser  = r_out_status;

    // each entry is pushed at most once, so the stack never outgrows the table
    `IGR_ASSERT(a_depth_bound, r_depth <= r_count, "walk stack deeper than table")
    // the clearing sweep and a scan never share the visited write port
    `IGR_ASSERT(a_vis_port, !(i_cmd.clr_en && r_eval_vld), "clear and scan overlap")

endmodule

/* rtl/interval_graph_reachability.sv */
// Top level of the interval graph reachability block.
// Depends on igr_pkg, igr_ctrl and igr_datapath.
//
//  channel   direction  tdata (low bit up)                          tuser
//  s_axis    in         left_end[31:0] right_end[63:32]             req_type
//                       from_entry[71:64] to_entry[79:72]
//  m_axis    out        reachable[0] assigned_entry[8:1] zeros      status
//
// An insert or a rejected query goes from the request straight to the result state.
// A query that names stored entries sweeps the visited marks over all N stored entries, then
// scans the N entries once per popped entry, through the single read port of the tables.
// Reset is synchronous, active low, and empties the table; no clearing pass is needed.
// A finished result waits in the output register while the next request is taken.
module interval_graph_reachability #(
    parameter int ENTRIES = igr_pkg::ENTRIES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    // left_end, right_end, from_entry, to_entry
    input  logic [igr_pkg::S_DATA_W-1:0]  i_s_tdata,
    // req_type
    input  logic                          i_s_tuser,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    // reachable, assigned_entry, zero fill
    output logic [igr_pkg::M_DATA_W-1:0]  o_m_tdata,
    // status
    output logic [igr_pkg::STATUS_W-1:0]  o_m_tuser
);

    igr_pkg::t_ctrl_cmd  w_cmd;
    igr_pkg::t_dp_status w_st;

    // sequencer
    igr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_st       (w_st),
        .o_cmd      (w_cmd)
    );

    // tables, walk and output register
    igr_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_st       (w_st),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

/* sim/tb_interval_graph_reachability.sv */
// Self-checking testbench for interval_graph_reachability: drives insert and query
// requests on the input stream and scores every reply against an internal predictor or
// a hand-typed reply. Depends on igr_pkg and the RTL of the block; reads no files.
module tb_interval_graph_reachability;

    localparam int ENTRIES     = igr_pkg::ENTRIES_DEF;
    localparam int HOLD_CYCLES = 300;
    localparam int IDLE_LIMIT  = 200000;
    localparam int TAIL_CYCLES = 20;

    // one reply of the block
    typedef struct packed {
        logic                         reach;
        logic [igr_pkg::STATUS_W-1:0] status;
        logic [igr_pkg::ENTRY_W-1:0]  assigned;
    } t_reply;

    // one request, with an optional hand-typed reply
    typedef struct packed {
        logic                             kind;
        logic signed [igr_pkg::END_W-1:0] left_end;
        logic signed [igr_pkg::END_W-1:0] right_end;
        logic [igr_pkg::ENTRY_W-1:0]      from_entry;
        logic [igr_pkg::ENTRY_W-1:0]      to_entry;
        logic                             has_typed;
        t_reply                           typed;
    } t_req;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_tvalid = 1'b0;
    logic                          o_s_tready;
    logic [igr_pkg::S_DATA_W-1:0]  i_s_tdata = '0;
    logic                          i_s_tuser = 1'b0;
    logic                          o_m_tvalid;
    logic                          i_m_tready = 1'b0;
    logic [igr_pkg::M_DATA_W-1:0]  o_m_tdata;
    logic [igr_pkg::STATUS_W-1:0]  o_m_tuser;

    // request held on the bus, seen by the scoreboard at acceptance
    t_req cur_req = '0;

    // predictor copy of the interval table
    logic signed [igr_pkg::END_W-1:0] left_tbl  [ENTRIES];
    logic signed [igr_pkg::END_W-1:0] right_tbl [ENTRIES];
    int stored_cnt = 0;

    t_reply pending_replies[$];
    int     mismatch_cnt = 0;

    // traffic shaping
    int s_idle_pct  = 0;
    int m_stall_pct = 0;
    int hold_token  = 0;
    int hold_seen   = 0;
    int hold_left   = 0;
    int quiet_cycles = 0;

    interval_graph_reachability #(.ENTRIES(ENTRIES)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),   // left_end, right_end, from_entry, to_entry
        .i_s_tuser  (i_s_tuser),   // req_type
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),   // reachable, assigned_entry, zero fill
        .o_m_tuser  (o_m_tuser)    // status
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // strict containment of a point in a stored interval
    function automatic bit lies_within(logic signed [igr_pkg::END_W-1:0] v, int slot);
        return (v > left_tbl[slot]) && (v < right_tbl[slot]);
    endfunction

    // depth-first walk over the overlap graph, marks cleared per query
    function automatic logic reaches(int start, int target);
        bit seen [ENTRIES];
        int stack_q[$];
        int x;
        int i;
        foreach (seen[k]) seen[k] = 1'b0;
        seen[start] = 1'b1;
        stack_q.push_back(start);
        while (stack_q.size() > 0) begin
            x = stack_q.pop_back();
            for (i = 0; i < stored_cnt; i++) begin
                if (!seen[i] && (lies_within(left_tbl[x], i) ||
                                 lies_within(right_tbl[x], i))) begin
                    seen[i] = 1'b1;
                    stack_q.push_back(i);
                end
            end
        end
        return seen[target];
    endfunction

    // expected reply for one accepted request; updates the table copy
    function automatic t_reply predict_reply(t_req r);
        t_reply rep;
        int a;
        int b;
        rep = '0;
        rep.status = igr_pkg::ST_OK;
        if (r.kind == igr_pkg::REQ_INSERT) begin
            if (stored_cnt >= ENTRIES) begin
                rep.status = igr_pkg::ST_FULL;
            end else begin
                left_tbl[stored_cnt]  = r.left_end;
                right_tbl[stored_cnt] = r.right_end;
                stored_cnt++;
                rep.assigned = 8'(stored_cnt);
            end
        end else begin
            a = r.from_entry;
            b = r.to_entry;
            if (a == 0 || b == 0 || a > stored_cnt || b > stored_cnt)
                rep.status = igr_pkg::ST_ABSENT;
            else
                rep.reach = reaches(a - 1, b - 1);
        end
        return rep;
    endfunction

    function automatic t_req mk_req(logic kind, int lo, int hi, int from_e, int to_e,
                                    bit typed, logic reach,
                                    logic [igr_pkg::STATUS_W-1:0] st, int asg);
        t_req r;
        r.kind           = kind;
        r.left_end       = lo;
        r.right_end      = hi;
        r.from_entry     = 8'(from_e);
        r.to_entry       = 8'(to_e);
        r.has_typed      = typed;
        r.typed.reach    = reach;
        r.typed.status   = st;
        r.typed.assigned = 8'(asg);
        return r;
    endfunction

    // endpoints: mostly a narrow band so that intervals chain, sometimes anything
    function automatic int rand_end();
        case ($urandom_range(0, 9))
            0: return int'($urandom);
            1: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: return int'($urandom_range(0, 400)) - 200;
        endcase
    endfunction

    // random request; queries mostly name stored entries, some are noise
    function automatic t_req gen_req(int cnt, int insert_pct);
        t_req r;
        r = mk_req(igr_pkg::REQ_QUERY, rand_end(), rand_end(), $urandom_range(0, 255),
                   $urandom_range(0, 255), 1'b0, 1'b0, igr_pkg::ST_OK, 0);
        if ($urandom_range(0, 99) < insert_pct) begin
            r.kind = igr_pkg::REQ_INSERT;
        end else if (cnt > 0 && $urandom_range(0, 99) < 85) begin
            r.from_entry = 8'($urandom_range(1, cnt));
            r.to_entry   = 8'($urandom_range(1, cnt));
        end
        return r;
    endfunction

    // offer one request, with random idle cycles ahead of it
    task automatic send_req(t_req r);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        cur_req    <= r;
        i_s_tdata  <= {r.to_entry, r.from_entry, r.right_end, r.left_end};
        i_s_tuser  <= r.kind;
        i_s_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
    endtask

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge i_clk) begin
        if (hold_seen != hold_token) begin
            hold_seen = hold_token;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= ($urandom_range(0, 99) >= m_stall_pct);
        end
    end

    // scoreboard: replies first, then new requests
    always @(posedge i_clk) begin : scoreboard
        t_reply got;
        t_reply want;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.reach    = o_m_tdata[0];
                got.assigned = o_m_tdata[8:1];
                got.status   = o_m_tuser;
                if (pending_replies.size() == 0) begin
                    mismatch_cnt++;
                    $display("%0t: unexpected reply, expected none, got reach=%0d status=%0d entry=%0d",
                             $time, got.reach, got.status, got.assigned);
                end else begin
                    want = pending_replies.pop_front();
                    if (got.reach !== want.reach) begin
                        mismatch_cnt++;
                        $display("%0t: reachable expected %0d got %0d",
                                 $time, want.reach, got.reach);
                    end
                    if (got.status !== want.status) begin
                        mismatch_cnt++;
                        $display("%0t: status expected %0d got %0d",
                                 $time, want.status, got.status);
                    end
                    if (got.assigned !== want.assigned) begin
                        mismatch_cnt++;
                        $display("%0t: assigned_entry expected %0d got %0d",
                                 $time, want.assigned, got.assigned);
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                want = predict_reply(cur_req);
                if (cur_req.has_typed)
                    want = cur_req.typed;
                pending_replies.push_back(want);
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_req dir_q[$];
        t_req r;
        int planned;
        int ph;
        planned = 0;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: empty table, endpoint extremes, empty intervals, bad entry numbers
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 1, 1, 1, 0, igr_pkg::ST_ABSENT, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF, 255, 255,
                               1, 0, igr_pkg::ST_OK, 1));
        dir_q.push_back(mk_req(igr_pkg::REQ_INSERT, 5, 5, 0, 0, 1, 0, igr_pkg::ST_OK, 2));
        dir_q.push_back(mk_req(igr_pkg::REQ_INSERT, 10, -10, 0, 0, 1, 0, igr_pkg::ST_OK, 3));
        dir_q.push_back(mk_req(igr_pkg::REQ_INSERT, 0, 20, 0, 0, 1, 0, igr_pkg::ST_OK, 4));
        dir_q.push_back(mk_req(igr_pkg::REQ_INSERT, 15, 30, 0, 0, 1, 0, igr_pkg::ST_OK, 5));
        dir_q.push_back(mk_req(igr_pkg::REQ_INSERT, 32'sh7FFF_FFFF, 32'sh8000_0000, 0, 0,
                               1, 0, igr_pkg::ST_OK, 6));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, -1, -1, 1, 1, 1, 1, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 3, 3, 1, 1, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 0, 1, 1, 0, igr_pkg::ST_ABSENT, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 1, 0, 1, 0, igr_pkg::ST_ABSENT, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 7, 1, 1, 0, igr_pkg::ST_ABSENT, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 1, 7, 1, 0, igr_pkg::ST_ABSENT, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 255, 1, 1, 0, igr_pkg::ST_ABSENT, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 128, 128, 1, 0, igr_pkg::ST_ABSENT, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 2, 1, 0, 0, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 1, 2, 0, 0, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 4, 5, 0, 0, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 5, 3, 0, 0, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 3, 4, 0, 0, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 6, 1, 0, 0, igr_pkg::ST_OK, 0));
        dir_q.push_back(mk_req(igr_pkg::REQ_QUERY, 0, 0, 5, 4, 0, 0, igr_pkg::ST_OK, 0));
        foreach (dir_q[k]) begin
            send_req(dir_q[k]);
            if (dir_q[k].kind == igr_pkg::REQ_INSERT && planned < ENTRIES) planned++;
        end

        // random phases: no idling, sender idle, receiver stalls, both
        for (ph = 0; ph < 4; ph++) begin
            s_idle_pct  = (ph == 1) ? 82 : (ph == 3) ? 18 : 0;
            m_stall_pct = (ph == 2) ? 82 : (ph == 3) ? 18 : 0;
            repeat (25) begin
                r = gen_req(planned, 55);
                send_req(r);
                if (r.kind == igr_pkg::REQ_INSERT && planned < ENTRIES) planned++;
            end
        end

        // long receiver hold-off while requests keep coming, then drain
        s_idle_pct  = 0;
        m_stall_pct = 0;
        hold_token++;
        repeat (8) begin
            r = gen_req(planned, 70);
            send_req(r);
            if (r.kind == igr_pkg::REQ_INSERT && planned < ENTRIES) planned++;
        end
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);

        // fill the table, overflow it, then query the full table
        s_idle_pct  = 18;
        m_stall_pct = 18;
        while (planned < ENTRIES) begin
            send_req(gen_req(planned, 100));
            planned++;
        end
        repeat (3) send_req(gen_req(planned, 100));
        repeat (12) send_req(gen_req(planned, 0));
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
